// ===== rtl/bis_pkg.sv =====
`default_nettype none

package bis_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int WEIGHT_BITS = 8;
  localparam int SCALE_FRAC  = 16;

  localparam int COORD_W    = 10;
  localparam int PIXEL_W    = 8;
  localparam int SCALE_W    = 20;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int BANK_AW    = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [SCALE_W-1:0] INV_SCALE_RST = SCALE_W'(65536);
  localparam logic [SIZE_W-1:0]  SRC_SIZE_RST  = SIZE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_SCALE_X = 2'd0,
    CFG_INV_SCALE_Y = 2'd1,
    CFG_SRC_WIDTH   = 2'd2,
    CFG_SRC_HEIGHT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIXEL_W-1:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               edge_clamped;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_image_scaler_core.sv =====
`default_nettype none

// Grayscale bilinear resizer over a 256x256 frame held in four on-chip banks split by row
// and column parity, so the four neighbours of a request are read together. A write
// request (action 0) stores one pixel inside the frame and gives no response; a request
// with action 1 gives one response. Six register stages: input, coordinate multiply,
// index clamp and bank address, bank read with weight products, pixel products, sum and
// output. One request enters per clock unless a stalled output holds back the pipeline.
// Writes and reads are issued from the same stage, so a request sees every write accepted
// before it. Reading a pixel that was never written returns an undefined value. Scale and
// size registers may be written only while the pipeline is empty.
module bilinear_image_scaler_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire bis_pkg::in_req_t                in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      bis_pkg::out_rsp_t               out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bis_pkg::*;

  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int PX_W   = PROD_W - SCALE_FRAC;
  localparam int W1     = WEIGHT_BITS + 1;
  localparam int WW     = 2 * W1;
  localparam int MW     = WW + PIXEL_W;
  localparam int SW     = MW + 2;
  localparam int VW     = SW - 2 * WEIGHT_BITS;
  localparam int ONE    = 1 << WEIGHT_BITS;
  localparam int WTOTAL = 1 << (2 * WEIGHT_BITS);
  localparam int PIXMAX = (1 << PIXEL_W) - 1;

  // configuration
  logic [SCALE_W-1:0] inv_scale_x_q, inv_scale_y_q;
  logic [SIZE_W-1:0]  src_width_q, src_height_q;
  logic [COL_W-1:0]   last_col;
  logic [ROW_W-1:0]   last_row;

  // stage valids and loads
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  // stage 1
  in_req_t s1_q;

  // stage 2
  logic [PROD_W-1:0]  s2_sx_q, s2_sy_q;
  logic               s2_act_q, s2_wok_q;
  logic [COL_W-1:0]   s2_wcol_q;
  logic [ROW_W-1:0]   s2_wrow_q;
  logic [PIXEL_W-1:0] s2_pix_q;

  // stage 3
  logic [COL_W-1:0]       s3_c0_q, s3_c1_q;
  logic [ROW_W-1:0]       s3_r0_q, s3_r1_q;
  logic [WEIGHT_BITS-1:0] s3_fx_q, s3_fy_q;
  logic                   s3_act_q, s3_wok_q, s3_hit_q;
  logic [PIXEL_W-1:0]     s3_pix_q;

  // stage 4
  logic [PIXEL_W-1:0] bank_rd_q [NUM_BANKS];
  logic [WW-1:0]      s4_w_q [NUM_BANKS];
  logic [1:0]         s4_sel_q [NUM_BANKS];
  logic               s4_hit_q;

  // stage 5
  logic [MW-1:0] s5_m_q [NUM_BANKS];
  logic          s5_hit_q;

  // stage 6
  out_rsp_t s6_q;

  // combinational
  logic [PROD_W-1:0]      sx_d, sy_d;
  logic                   wok_d;
  logic [PX_W-1:0]        px, py;
  logic [PX_W:0]          px1, py1;
  logic [COL_W-1:0]       c0_d, c1_d;
  logic [ROW_W-1:0]       r0_d, r1_d;
  logic                   hit_d;
  logic [W1-1:0]          gx, gy, fxe, fye;
  logic [WW-1:0]          w_d [NUM_BANKS];
  logic [1:0]             sel_d [NUM_BANKS];
  logic [MW-1:0]          m_d [NUM_BANKS];
  logic [SW-1:0]          acc;
  logic [VW-1:0]          val;
  logic [NUM_BANKS-1:0]   bank_we;

  // handshake chain
  assign ld6 = !v6_q || out_ready_i;
  assign ld5 = !v5_q || ld6;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign in_ready_o  = ld1;
  assign out_valid_o = v6_q;
  assign out_data_o  = s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      v5_q          <= 1'b0;
      v6_q          <= 1'b0;
      inv_scale_x_q <= INV_SCALE_RST;
      inv_scale_y_q <= INV_SCALE_RST;
      src_width_q   <= SRC_SIZE_RST;
      src_height_q  <= SRC_SIZE_RST;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q && (s3_act_q == ACT_REQUEST);
      if (ld5) v5_q <= v4_q;
      if (ld6) v6_q <= v5_q;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_INV_SCALE_X: inv_scale_x_q <= cfg_data_i[SCALE_W-1:0];
          CFG_INV_SCALE_Y: inv_scale_y_q <= cfg_data_i[SCALE_W-1:0];
          CFG_SRC_WIDTH:   src_width_q   <= cfg_data_i[SIZE_W-1:0];
          CFG_SRC_HEIGHT:  src_height_q  <= cfg_data_i[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // last valid column and row
  always_comb begin
    if (src_width_q == '0) begin
      last_col = '0;
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(src_width_q - 1'b1);
    end
    if (src_height_q == '0) begin
      last_row = '0;
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(src_height_q - 1'b1);
    end
  end

  // stage 1 -> 2: coordinate multiply
  assign sx_d  = PROD_W'(s1_q.coord_x) * PROD_W'(inv_scale_x_q);
  assign sy_d  = PROD_W'(s1_q.coord_y) * PROD_W'(inv_scale_y_q);
  assign wok_d = (s1_q.action == ACT_WRITE) && (32'(s1_q.coord_x) < MAX_WIDTH)
                 && (32'(s1_q.coord_y) < MAX_HEIGHT);

  // stage 2 -> 3: integer position, clamp
  assign px  = s2_sx_q[SCALE_FRAC +: PX_W];
  assign py  = s2_sy_q[SCALE_FRAC +: PX_W];
  assign px1 = {1'b0, px} + (PX_W+1)'(1);
  assign py1 = {1'b0, py} + (PX_W+1)'(1);

  always_comb begin
    hit_d = 1'b0;
    if (px > PX_W'(last_col)) begin
      c0_d  = last_col;
      hit_d = 1'b1;
    end else begin
      c0_d = px[COL_W-1:0];
    end
    if (px1 > (PX_W+1)'(last_col)) begin
      c1_d  = last_col;
      hit_d = 1'b1;
    end else begin
      c1_d = px1[COL_W-1:0];
    end
    if (py > PX_W'(last_row)) begin
      r0_d  = last_row;
      hit_d = 1'b1;
    end else begin
      r0_d = py[ROW_W-1:0];
    end
    if (py1 > (PX_W+1)'(last_row)) begin
      r1_d  = last_row;
      hit_d = 1'b1;
    end else begin
      r1_d = py1[ROW_W-1:0];
    end
    if (s2_act_q == ACT_WRITE) begin
      c0_d = s2_wcol_q;
      r0_d = s2_wrow_q;
    end
  end

  // stage 3 -> 4: weights; bank select index is {row parity, column parity}
  assign fxe = W1'(s3_fx_q);
  assign fye = W1'(s3_fy_q);
  assign gx  = W1'(ONE) - fxe;
  assign gy  = W1'(ONE) - fye;

  always_comb begin
    w_d[0]   = WW'(gx) * WW'(gy);
    w_d[1]   = WW'(fxe) * WW'(gy);
    w_d[2]   = WW'(gx) * WW'(fye);
    w_d[3]   = WW'(fxe) * WW'(fye);
    sel_d[0] = {s3_r0_q[0], s3_c0_q[0]};
    sel_d[1] = {s3_r0_q[0], s3_c1_q[0]};
    sel_d[2] = {s3_r1_q[0], s3_c0_q[0]};
    sel_d[3] = {s3_r1_q[0], s3_c1_q[0]};
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic RP = 1'(b >> 1);
    localparam logic CP = 1'(b);
    logic [PIXEL_W-1:0] mem [BANK_DEPTH];
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [BANK_AW-1:0] addr;

    assign row  = (s3_r0_q[0] == RP) ? s3_r0_q : s3_r1_q;
    assign col  = (s3_c0_q[0] == CP) ? s3_c0_q : s3_c1_q;
    assign addr = {row[ROW_W-1:1], col[COL_W-1:1]};
    assign bank_we[b] = ld4 && v3_q && s3_wok_q && (s3_r0_q[0] == RP)
                        && (s3_c0_q[0] == CP);

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) mem[addr] <= s3_pix_q;
      if (ld4) bank_rd_q[b] <= mem[addr];
    end
  end

  // stage 4 -> 5: pixel products
  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      m_d[k] = MW'(s4_w_q[k]) * MW'(bank_rd_q[s4_sel_q[k]]);
    end
  end

  // stage 5 -> 6: sum, truncate and saturate
  assign acc = SW'(s5_m_q[0]) + SW'(s5_m_q[1]) + SW'(s5_m_q[2]) + SW'(s5_m_q[3]);
  assign val = acc[SW-1:2*WEIGHT_BITS];

  always_ff @(posedge clk_i) begin
    if (ld1) s1_q <= in_data_i;
    if (ld2) begin
      s2_sx_q   <= sx_d;
      s2_sy_q   <= sy_d;
      s2_act_q  <= s1_q.action;
      s2_wok_q  <= wok_d;
      s2_wcol_q <= s1_q.coord_x[COL_W-1:0];
      s2_wrow_q <= s1_q.coord_y[ROW_W-1:0];
      s2_pix_q  <= s1_q.pixel_in;
    end
    if (ld3) begin
      s3_c0_q  <= c0_d;
      s3_c1_q  <= c1_d;
      s3_r0_q  <= r0_d;
      s3_r1_q  <= r1_d;
      s3_fx_q  <= s2_sx_q[SCALE_FRAC-1 -: WEIGHT_BITS];
      s3_fy_q  <= s2_sy_q[SCALE_FRAC-1 -: WEIGHT_BITS];
      s3_hit_q <= hit_d;
      s3_act_q <= s2_act_q;
      s3_wok_q <= s2_wok_q;
      s3_pix_q <= s2_pix_q;
    end
    if (ld4) begin
      s4_w_q   <= w_d;
      s4_sel_q <= sel_d;
      s4_hit_q <= s3_hit_q;
    end
    if (ld5) begin
      s5_m_q   <= m_d;
      s5_hit_q <= s4_hit_q;
    end
    if (ld6) begin
      s6_q.pixel_out    <= (val > VW'(PIXMAX)) ? PIXEL_W'(PIXMAX) : val[PIXEL_W-1:0];
      s6_q.edge_clamped <= s5_hit_q;
    end
  end

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one bank written");

  a_cols_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (s3_act_q == ACT_REQUEST) |-> s3_c0_q <= last_col && s3_c1_q <= last_col
      && (s3_c1_q == s3_c0_q || {1'b0, s3_c1_q} == {1'b0, s3_c0_q} + 1'b1))
    else $error("neighbour columns out of frame or not adjacent");

  a_rows_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (s3_act_q == ACT_REQUEST) |-> s3_r0_q <= last_row && s3_r1_q <= last_row
      && (s3_r1_q == s3_r0_q || {1'b0, s3_r1_q} == {1'b0, s3_r0_q} + 1'b1))
    else $error("neighbour rows out of frame or not adjacent");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (WW+2)'(s4_w_q[0]) + (WW+2)'(s4_w_q[1]) + (WW+2)'(s4_w_q[2])
      + (WW+2)'(s4_w_q[3]) == (WW+2)'(WTOTAL))
    else $error("bilinear weights do not sum to one");

endmodule

`default_nettype wire

// ===== sim/bilinear_image_scaler_core_tb.sv =====
module bilinear_image_scaler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned COORD_MAX    = (1 << COORD_W) - 1;
  localparam longint unsigned W_ONE    = 64'd1 << WEIGHT_BITS;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_req_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_rsp_t              out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  bilinear_image_scaler_core DUT (.*);

  // shadow of the frame store and scaler registers
  logic [PIXEL_W-1:0] frame_mem [MAX_WIDTH*MAX_HEIGHT];
  bit                 filled    [MAX_WIDTH*MAX_HEIGHT];
  logic [SCALE_W-1:0] scale_x    = INV_SCALE_RST;
  logic [SCALE_W-1:0] scale_y    = INV_SCALE_RST;
  logic [SIZE_W-1:0]  width_reg  = SRC_SIZE_RST;
  logic [SIZE_W-1:0]  height_reg = SRC_SIZE_RST;

  in_req_t     req_queue[$];
  out_rsp_t    expected_pixels[$];
  out_rsp_t    head_rsp;
  int unsigned mismatches, results_seen, writes_sent, requests_sent, settings_run, cycle_cnt;
  int unsigned burst_left, gap_left, mode_left, hold_left, ready_pct;
  bit          long_hold_done;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void accept_request(in_req_t r);
    longint unsigned sx, sy, fx, fy, px, py, lastc, lastr, c0, c1, r0, r1, acc;
    out_rsp_t        rsp;
    if (r.action == ACT_WRITE) begin
      if (r.coord_x < MAX_WIDTH && r.coord_y < MAX_HEIGHT)
        frame_mem[r.coord_y * MAX_WIDTH + r.coord_x] = r.pixel_in;
      return;
    end
    sx = 64'(r.coord_x) * 64'(scale_x);
    sy = 64'(r.coord_y) * 64'(scale_y);
    fx = (sx >> (SCALE_FRAC - WEIGHT_BITS)) & (W_ONE - 1);
    fy = (sy >> (SCALE_FRAC - WEIGHT_BITS)) & (W_ONE - 1);
    px = sx >> SCALE_FRAC;
    py = sy >> SCALE_FRAC;
    lastc = eff_size(width_reg, MAX_WIDTH) - 1;
    lastr = eff_size(height_reg, MAX_HEIGHT) - 1;
    c0 = (px > lastc) ? lastc : px;
    c1 = (px + 1 > lastc) ? lastc : px + 1;
    r0 = (py > lastr) ? lastr : py;
    r1 = (py + 1 > lastr) ? lastr : py + 1;
    acc = (W_ONE - fx) * (W_ONE - fy) * frame_mem[r0 * MAX_WIDTH + c0]
        + fx * (W_ONE - fy) * frame_mem[r0 * MAX_WIDTH + c1]
        + (W_ONE - fx) * fy * frame_mem[r1 * MAX_WIDTH + c0]
        + fx * fy * frame_mem[r1 * MAX_WIDTH + c1];
    acc = acc >> (2 * WEIGHT_BITS);
    rsp.pixel_out    = (acc > 255) ? 8'hFF : acc[PIXEL_W-1:0];
    rsp.edge_clamped = (px + 1 > lastc) || (py + 1 > lastr);
    expected_pixels.push_back(rsp);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return SCALE_W'($urandom);
      1: return INV_SCALE_RST;
      default: return SCALE_W'($urandom_range(32'h02000, 32'h30000));
    endcase
  endfunction

  function automatic void push_write(int unsigned x, int unsigned y, logic [PIXEL_W-1:0] p);
    in_req_t r;
    r.action   = ACT_WRITE;
    r.coord_x  = COORD_W'(x);
    r.coord_y  = COORD_W'(y);
    r.pixel_in = p;
    req_queue.push_back(r);
    if (x < MAX_WIDTH && y < MAX_HEIGHT) begin
      filled[y * MAX_WIDTH + x] = 1'b1;
      writes_sent++;
    end
  endfunction

  function automatic void push_read(int unsigned x, int unsigned y);
    in_req_t r;
    r.action   = ACT_REQUEST;
    r.coord_x  = COORD_W'(x);
    r.coord_y  = COORD_W'(y);
    r.pixel_in = PIXEL_W'($urandom);
    req_queue.push_back(r);
    requests_sent++;
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (req_queue.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INV_SCALE_X: scale_x    = data[SCALE_W-1:0];
      CFG_INV_SCALE_Y: scale_y    = data[SCALE_W-1:0];
      CFG_SRC_WIDTH:   width_reg  = data[SIZE_W-1:0];
      CFG_SRC_HEIGHT:  height_reg = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // program a setting, then write every frame pixel a request could touch
  task automatic configure(logic [SCALE_W-1:0] isx, logic [SCALE_W-1:0] isy,
                           logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    logic [CFG_DATA_W-SIZE_W-1:0] junk_w, junk_h;
    junk_w = ($urandom_range(0, 1) == 0) ? '0 : (CFG_DATA_W-SIZE_W)'($urandom);
    junk_h = ($urandom_range(0, 1) == 0) ? '0 : (CFG_DATA_W-SIZE_W)'($urandom);
    wait_idle();
    write_reg(CFG_INV_SCALE_X, isx);
    write_reg(CFG_INV_SCALE_Y, isy);
    write_reg(CFG_SRC_WIDTH, {junk_w, w});
    write_reg(CFG_SRC_HEIGHT, {junk_h, h});
    settings_run++;
    for (int y = 0; y < eff_size(h, MAX_HEIGHT); y++)
      for (int x = 0; x < eff_size(w, MAX_WIDTH); x++)
        if (!filled[y * MAX_WIDTH + x]) push_write(x, y, rand_pixel());
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned wf, hf, xmax, ymax;
    wf   = eff_size(width_reg, MAX_WIDTH);
    hf   = eff_size(height_reg, MAX_HEIGHT);
    xmax = (scale_x == 0) ? COORD_MAX : ((wf + 1) << SCALE_FRAC) / scale_x;
    ymax = (scale_y == 0) ? COORD_MAX : ((hf + 1) << SCALE_FRAC) / scale_y;
    if (xmax > COORD_MAX) xmax = COORD_MAX;
    if (ymax > COORD_MAX) ymax = COORD_MAX;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: push_write($urandom_range(0, wf - 1), $urandom_range(0, hf - 1), rand_pixel());
        2: push_write($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                      rand_pixel());
        3: begin
          if ($urandom_range(0, 1) == 0)
            push_write($urandom_range(MAX_WIDTH, COORD_MAX), $urandom_range(0, COORD_MAX),
                       rand_pixel());
          else
            push_write($urandom_range(0, COORD_MAX), $urandom_range(MAX_HEIGHT, COORD_MAX),
                       rand_pixel());
        end
        4, 5: push_read($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        default: push_read($urandom_range(0, xmax), $urandom_range(0, ymax));
      endcase
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) accept_request(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_queue.size() != 0) begin
          in_data_i  <= req_queue.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result backpressure: random modes plus one long hold while requests are queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= 100 && req_queue.size() >= 40) begin
        long_hold_done = 1'b1;
        hold_left      = 400;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: pixel %0d clamp %0b", out_data_o.pixel_out,
                   out_data_o.edge_clamped);
        mismatches++;
      end else begin
        head_rsp = expected_pixels.pop_front();
        if (out_data_o.pixel_out !== head_rsp.pixel_out ||
            out_data_o.edge_clamped !== head_rsp.edge_clamped) begin
          if (mismatches < 10)
            $display("result %0d: expected pixel %0d clamp %0b, got pixel %0d clamp %0b",
                     results_seen, head_rsp.pixel_out, head_rsp.edge_clamped,
                     out_data_o.pixel_out, out_data_o.edge_clamped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned        base;
    logic [SCALE_W-1:0] isx, isy;
    logic [SIZE_W-1:0]  w, h;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: 4x3 frame, half-step x, two-thirds step y
    configure(20'h08000, 20'h0AAAA, 9'd4, 9'd3);
    push_write(COORD_MAX, 5, 8'hAA);
    push_write(5, COORD_MAX, 8'h55);
    push_write(MAX_WIDTH - 1, MAX_HEIGHT - 1, 8'hFF);
    push_write(0, 0, 8'hFF);
    push_write(3, 2, 8'h00);
    push_read(0, 0);
    push_read(1, 1);
    push_write(1, 1, 8'h80);
    push_read(2, 1);
    push_read(6, 2);
    push_read(7, 3);
    push_read(COORD_MAX, COORD_MAX);
    push_read(0, COORD_MAX);
    base = writes_sent + requests_sent;

    configure(20'h00000, 20'h00000, 9'd5, 9'd5);
    random_traffic(60);
    configure(20'hFFFFF, 20'hFFFFF, 9'd3, 9'd2);
    random_traffic(60);
    configure(20'h10000, 20'h04000, 9'd256, 9'd1);
    random_traffic(80);
    configure(20'h02000, 20'h10000, 9'd0, 9'd256);
    random_traffic(80);
    configure(20'h18000, 20'h0C000, 9'd511, 9'd0);
    random_traffic(60);
    configure(20'h10000, 20'h10000, 9'd1, 9'd1);
    random_traffic(40);

    while (writes_sent + requests_sent < base + RANDOM_ITEMS) begin
      isx = rand_scale();
      isy = rand_scale();
      w   = SIZE_W'($urandom_range(1, 16));
      h   = SIZE_W'($urandom_range(1, 16));
      case ($urandom_range(0, 9))
        0: w = '0;
        1: h = '0;
        2: begin
          w = SIZE_W'($urandom_range(MAX_WIDTH + 1, 511));
          h = 9'd1;
        end
        default: ;
      endcase
      configure(isx, isy, w, h);
      random_traffic($urandom_range(60, 140));
    end

    wait_idle();
    $display("covered %0d pixel writes and %0d interpolation requests, %0d results checked",
             writes_sent, requests_sent, results_seen);
    $display("over %0d scaler settings incl. zero/max scale, edge clamps, odd size codes",
             settings_run);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
